/* hdl/hashed_value_noise_catmull_rom_macros.svh */
// Assertion macros shared by the hashed value noise block.
`ifndef HASHED_VALUE_NOISE_CATMULL_ROM_MACROS_SVH
`define HASHED_VALUE_NOISE_CATMULL_ROM_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define HVN_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication over a fixed number of cycles, switched off while reset is high.
`define HVN_ASSERT_LATER(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error(msg);

// Implication that is checked during reset as well.
`define HVN_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* hdl/hvn_pkg.sv */
// Package with widths, hash constants and shared types of the value noise block.
`timescale 1ns / 1ps

package hvn_pkg;

   localparam int POS_W   = 32;
   localparam int FRAC_W  = 16;
   localparam int POINT_W = 17;
   localparam int HASH_W  = 32;
   localparam int AMP_W   = 23;
   localparam int PAT_W   = 14;
   localparam int OUT_W   = 25;
   localparam int COEF_W  = 28;
   localparam int RES_W   = COEF_W - 1;
   localparam int PROD_W  = COEF_W + FRAC_W + 1;
   localparam int SCALE_W = HASH_W + AMP_W;

   localparam int NUM_POINTS  = 4;
   localparam int HASH_STAGES = 4;
   localparam int LATENCY     = 9;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = AMP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 2'd2;

   localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 23'd549033;

   localparam logic [HASH_W-1:0] HASH_MUL_A = 32'h7feb352d;
   localparam logic [HASH_W-1:0] HASH_MUL_B = 32'h846ca68b;
   localparam logic [HASH_W-1:0] HASH_XOR   = 32'h9e3779b9;
   localparam logic [HASH_W-1:0] NEG_BASE   = 32'd10000;
   localparam logic [HASH_W-1:0] KEY_OFFSET = 32'd10;

   localparam logic signed [RES_W-1:0] OUT_MAX = 27'sd16777215;
   localparam logic signed [RES_W-1:0] OUT_MIN = -27'sd16777216;

   typedef struct packed {
      logic             noise_enable;
      logic [AMP_W-1:0] amplitude;
   } cfg_type;

endpackage

/* hdl/hvn_hash.sv */
// Four-stage hash pipeline that maps one lattice point to a scaled Q3.20 value.
`timescale 1ns / 1ps

module hvn_hash (
   input  logic                                clock,
   input  logic signed [hvn_pkg::POINT_W-1:0]  point,
   input  logic        [hvn_pkg::HASH_W-1:0]   key,
   input  logic        [hvn_pkg::AMP_W-1:0]    amplitude,
   output logic        [hvn_pkg::AMP_W-1:0]    scaled
);

   logic [hvn_pkg::HASH_W-1:0]  ext;
   logic [hvn_pkg::HASH_W-1:0]  idx;
   logic [hvn_pkg::HASH_W-1:0]  rot;
   logic [hvn_pkg::HASH_W-1:0]  x0;
   logic [hvn_pkg::HASH_W-1:0]  y2;
   logic [hvn_pkg::HASH_W-1:0]  h;
   logic [hvn_pkg::SCALE_W-1:0] prod;

   logic [hvn_pkg::HASH_W-1:0] x1_ff, x1_in;
   logic [hvn_pkg::HASH_W-1:0] x2_ff, x2_in;
   logic [hvn_pkg::HASH_W-1:0] x3_ff, x3_in;
   logic [hvn_pkg::AMP_W-1:0]  f_ff, f_in;

   always_comb begin
      ext   = {{(hvn_pkg::HASH_W - hvn_pkg::POINT_W){point[hvn_pkg::POINT_W-1]}}, point};
      idx   = point[hvn_pkg::POINT_W-1] ? (hvn_pkg::NEG_BASE - ext) : (ext + 32'd1);
      rot   = {idx[15:0], idx[31:16]};
      x0    = key ^ rot ^ hvn_pkg::HASH_XOR;
      x1_in = x0 ^ (x0 >> 16);
      x2_in = x1_ff * hvn_pkg::HASH_MUL_A;
      y2    = x2_ff ^ (x2_ff >> 15);
      x3_in = y2 * hvn_pkg::HASH_MUL_B;
      h     = x3_ff ^ (x3_ff >> 16);
      prod  = {{hvn_pkg::AMP_W{1'b0}}, h} * {{hvn_pkg::HASH_W{1'b0}}, amplitude};
      f_in  = prod[hvn_pkg::SCALE_W-1:hvn_pkg::HASH_W];
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      x3_ff <= x3_in;
      f_ff  <= f_in;
   end

   assign scaled = f_ff;

endmodule

/* hdl/hvn_interp.sv */
// Four-stage Catmull-Rom pipeline: coefficients, three Horner steps and the output select.
`timescale 1ns / 1ps

module hvn_interp (
   input  logic                                                    clock,
   input  logic [hvn_pkg::NUM_POINTS-1:0][hvn_pkg::AMP_W-1:0]      f,
   input  logic [hvn_pkg::FRAC_W-1:0]                              t,
   input  hvn_pkg::cfg_type                                        cfg,
   output logic signed [hvn_pkg::OUT_W-1:0]                        sway_value
);

   logic signed [hvn_pkg::COEF_W-1:0] fe0, fe1, fe2, fe3;
   logic signed [hvn_pkg::PROD_W-1:0] p1, p2, p3;
   logic signed [hvn_pkg::COEF_W-1:0] a3;
   logic signed [hvn_pkg::RES_W-1:0]  res;
   logic signed [hvn_pkg::OUT_W-1:0]  sat;

   logic signed [hvn_pkg::COEF_W-1:0] c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic        [hvn_pkg::FRAC_W-1:0] t1_ff, t2_ff, t3_ff;
   logic signed [hvn_pkg::COEF_W-1:0] c0_s2_ff, c1_s2_ff, c0_s3_ff;
   logic signed [hvn_pkg::COEF_W-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic signed [hvn_pkg::OUT_W-1:0]  sway_ff, sway_in;

   always_comb begin
      fe0 = $signed({{(hvn_pkg::COEF_W - hvn_pkg::AMP_W){1'b0}}, f[0]});
      fe1 = $signed({{(hvn_pkg::COEF_W - hvn_pkg::AMP_W){1'b0}}, f[1]});
      fe2 = $signed({{(hvn_pkg::COEF_W - hvn_pkg::AMP_W){1'b0}}, f[2]});
      fe3 = $signed({{(hvn_pkg::COEF_W - hvn_pkg::AMP_W){1'b0}}, f[3]});
      c0_in = fe1 <<< 1;
      c1_in = fe2 - fe0;
      c2_in = (fe0 <<< 1) - (fe1 <<< 2) - fe1 + (fe2 <<< 2) - fe3;
      c3_in = (fe1 <<< 1) + fe1 - (fe2 <<< 1) - fe2 + fe3 - fe0;

      p1    = c3_ff * $signed({1'b0, t1_ff});
      a1_in = p1[hvn_pkg::COEF_W+hvn_pkg::FRAC_W-1:hvn_pkg::FRAC_W] + c2_ff;

      p2    = a1_ff * $signed({1'b0, t2_ff});
      a2_in = p2[hvn_pkg::COEF_W+hvn_pkg::FRAC_W-1:hvn_pkg::FRAC_W] + c1_s2_ff;

      p3  = a2_ff * $signed({1'b0, t3_ff});
      a3  = p3[hvn_pkg::COEF_W+hvn_pkg::FRAC_W-1:hvn_pkg::FRAC_W] + c0_s3_ff;
      res = a3[hvn_pkg::COEF_W-1:1];
      if (res > hvn_pkg::OUT_MAX) begin
         sat = hvn_pkg::OUT_MAX[hvn_pkg::OUT_W-1:0];
      end else if (res < hvn_pkg::OUT_MIN) begin
         sat = hvn_pkg::OUT_MIN[hvn_pkg::OUT_W-1:0];
      end else begin
         sat = res[hvn_pkg::OUT_W-1:0];
      end
      if (cfg.noise_enable) begin
         sway_in = sat;
      end else begin
         sway_in = $signed({{(hvn_pkg::OUT_W - hvn_pkg::AMP_W){1'b0}}, cfg.amplitude});
      end
   end

   always_ff @(posedge clock) begin
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      c3_ff    <= c3_in;
      t1_ff    <= t;
      a1_ff    <= a1_in;
      c0_s2_ff <= c0_ff;
      c1_s2_ff <= c1_ff;
      t2_ff    <= t1_ff;
      a2_ff    <= a2_in;
      c0_s3_ff <= c0_s2_ff;
      t3_ff    <= t2_ff;
      sway_ff  <= sway_in;
   end

   assign sway_value = sway_ff;

endmodule

/* hdl/hashed_value_noise_catmull_rom.sv */
// Top level of the hashed 1-D value noise block with Catmull-Rom interpolation.
//
// Channel    Ports                              Transfer
// request    start, busy, req_position          start high while busy low
// response   rsp_valid, rsp_sway_value          one-cycle strobe, no back-pressure
// config     csr_wr_en, csr_index, csr_wdata    write enable high, no wait
//
// A transaction can be taken in every cycle; busy is high only while reset is high.
// Its result appears after an input register, four hash stages per lattice point,
// a coefficient stage, two Horner stages and the output register, each stage
// holding one multiplier at most.
// Reset clears the valid bits and loads the configuration reset values.
// The response side cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

`include "hashed_value_noise_catmull_rom_macros.svh"

module hashed_value_noise_catmull_rom (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [hvn_pkg::POS_W-1:0]        req_position,
   output logic                                    rsp_valid,
   output logic signed [hvn_pkg::OUT_W-1:0]        rsp_sway_value,
   input  logic                                    csr_wr_en,
   input  logic        [hvn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [hvn_pkg::CSR_W-1:0]        csr_wdata
);

   logic                                noise_enable_ff;
   logic [hvn_pkg::PAT_W-1:0]           pattern_ff;
   logic [hvn_pkg::AMP_W-1:0]           amplitude_ff;
   logic [hvn_pkg::LATENCY-1:0]         vld_ff, vld_in;
   logic signed [hvn_pkg::POS_W-1:0]    pos_ff;
   logic [hvn_pkg::FRAC_W-1:0]          t_dly_ff [hvn_pkg::HASH_STAGES];

   logic                                accept;
   logic [hvn_pkg::HASH_W-1:0]          key;
   logic signed [hvn_pkg::POINT_W-1:0]  k_ext;
   logic signed [hvn_pkg::POINT_W-1:0]  point [hvn_pkg::NUM_POINTS];
   logic [hvn_pkg::NUM_POINTS-1:0][hvn_pkg::AMP_W-1:0] scaled;
   hvn_pkg::cfg_type                    cfg;

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[hvn_pkg::LATENCY-2:0], accept};
   assign key    = 32'd0 - ({{(hvn_pkg::HASH_W - hvn_pkg::PAT_W){1'b0}}, pattern_ff}
                            + hvn_pkg::KEY_OFFSET);
   assign cfg.noise_enable = noise_enable_ff;
   assign cfg.amplitude    = amplitude_ff;

   always_comb begin
      k_ext = {pos_ff[hvn_pkg::POS_W-1], pos_ff[hvn_pkg::POS_W-1:hvn_pkg::FRAC_W]};
      for (int i = 0; i < hvn_pkg::NUM_POINTS; i++) begin
         point[i] = k_ext + hvn_pkg::POINT_W'(i) - 17'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_enable_ff <= 1'b0;
         pattern_ff      <= '0;
         amplitude_ff    <= hvn_pkg::AMPLITUDE_RESET;
         vld_ff          <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            case (csr_index)
               hvn_pkg::CSR_NOISE_ENABLE: noise_enable_ff <= csr_wdata[0];
               hvn_pkg::CSR_PATTERN:      pattern_ff      <= csr_wdata[hvn_pkg::PAT_W-1:0];
               hvn_pkg::CSR_AMPLITUDE:    amplitude_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= req_position;
      t_dly_ff[0] <= pos_ff[hvn_pkg::FRAC_W-1:0];
      for (int i = 1; i < hvn_pkg::HASH_STAGES; i++) begin
         t_dly_ff[i] <= t_dly_ff[i-1];
      end
   end

   for (genvar g = 0; g < hvn_pkg::NUM_POINTS; g++) begin : g_lane
      hvn_hash u_hash (
         .clock     (clock),
         .point     (point[g]),
         .key       (key),
         .amplitude (amplitude_ff),
         .scaled    (scaled[g])
      );
   end

   hvn_interp u_interp (
      .clock      (clock),
      .f          (scaled),
      .t          (t_dly_ff[hvn_pkg::HASH_STAGES-1]),
      .cfg        (cfg),
      .sway_value (rsp_sway_value)
   );

   assign rsp_valid = vld_ff[hvn_pkg::LATENCY-1];

   `HVN_ASSERT_LATER(a_resp_follows, accept, hvn_pkg::LATENCY, rsp_valid, "transaction lost in pipeline")
   `HVN_ASSERT_IMPL(a_resp_has_source, rsp_valid, $past(accept, hvn_pkg::LATENCY), "response without transaction")
   `HVN_ASSERT_ALWAYS(a_reset_quiet, $past(reset), !rsp_valid, "response right after reset")

endmodule
